>>> rtl/core/srmm_pkg.sv
// Package for the step response metrics monitor: widths, register indexes
// and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srmm_pkg;
   localparam int TimeW = 48;
   localparam int ValW = 32;
   localparam int AccW = 47;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 32;

   localparam logic [CsrIdxW-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_STEP_THRESHOLD = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SETTLE_FRACTION = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SETTLE_FLOOR = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SAMPLE_WEIGHT = 3'd4;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Divider handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;
endpackage
`default_nettype wire

>>> rtl/core/srmm_mul.sv
// Shared shift-add multiplier, one bit a cycle, unsigned 32 by 32.
// Uses srmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srmm_mul
   import srmm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic             done,
   output logic [63:0]      prod
);
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = {32'd0, a};
         mplier_in = b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in = {mcand_ff[62:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[31:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

>>> rtl/core/srmm_div.sv
// Restoring divider, one quotient bit a cycle, 64 by 32 unsigned.
// Uses srmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srmm_div
   import srmm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[31:0], quo_ff[63]};
      diff = {1'b0, trial} - {2'b00, den_ff};
      if (req.start) begin
         quo_in = req.num;
         rem_in = '0;
         den_in = req.den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;
endmodule
`default_nettype wire

>>> rtl/core/step_response_metrics_monitor_core.sv
// Top level of the step response metrics monitor: sequencer, state and
// registers. Uses srmm_pkg, srmm_mul and srmm_div.
`timescale 1ns / 1ps
`default_nettype none
// One request yields one response. A clear or a disabled sample skips the
// multiplies; an enabled sample runs five multiplies on the shared shift-add
// multiplier, and one that settles adds a multiply and, when the denominator is
// nonzero, a divide for overshoot. The response waits in its output register;
// the next request is taken once it has been taken.
module step_response_metrics_monitor_core
   import srmm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire logic [TimeW-1:0]    req_time_us,
   input  wire logic signed [31:0]  req_setpoint,
   input  wire logic signed [31:0]  req_measured,
   input  wire logic signed [31:0]  req_loop_error,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_metrics_valid,
   output logic                     rsp_tracking,
   output logic [TimeW-1:0]         rsp_settling_time_us,
   output logic signed [31:0]       rsp_overshoot_pct,
   output logic signed [31:0]       rsp_steady_error,
   output logic [AccW-1:0]          rsp_iae_out,
   output logic [AccW-1:0]          rsp_ise_out,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_M_IAE = 12'b000000000010,
      S_M_SQ  = 12'b000000000100,
      S_M_ISE = 12'b000000001000,
      S_M_ISH = 12'b000000010000,
      S_M_BND = 12'b000000100000,
      S_DECIDE= 12'b000001000000,
      S_M_OS1 = 12'b000010000000,
      S_M_OS2 = 12'b000100000000,
      S_DIV   = 12'b001000000000,
      S_FIN   = 12'b010000000000,
      S_RESP  = 12'b100000000000
   } state_type;

   localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

   state_type state_ff, state_in;

   logic        enable_ff;
   logic [30:0] threshold_ff, floor_ff;
   logic [15:0] fraction_ff, weight_ff;

   logic                   op_ff;
   logic [TimeW-1:0]       t_ff;
   logic signed [31:0]     sp_ff, meas_ff, err_ff;

   logic                   trk_ff;
   logic signed [31:0]     init_ff, tgt_ff, peak_ff;
   logic [TimeW-1:0]       start_ff;
   logic [AccW-1:0]        iae_ff, ise_ff;
   logic                   lv_ff;
   logic [TimeW-1:0]       lt_ff;
   logic signed [31:0]     los_ff, lse_ff;
   logic [AccW-1:0]        liae_ff, lise_ff;
   logic [63:0]            tmp_ff;
   logic                   neg_ff;
   logic [31:0]            den_ff;
   logic [14:0]            sqhi_ff;
   logic [47:0]            isel_ff;

   logic        mul_start;
   logic [31:0] mul_a, mul_b;
   logic        mul_done;
   logic [63:0] mul_p;
   div_req_type dreq;
   div_rsp_type drsp;

   srmm_mul u_mul (.clock(clock), .reset(reset), .start(mul_start), .a(mul_a),
      .b(mul_b), .done(mul_done), .prod(mul_p));
   srmm_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [32:0] ea, sa;
   logic [33:0] dsp, dms, dos_num, dos_den;
   logic [32:0] dsp_mag, dms_mag, num_mag, den_mag;
   logic [47:0] band;
   logic        start_step;
   logic        trk_now;
   logic signed [31:0] peak_now;
   logic signed [31:0] tgt_now, init_now;

   function automatic logic [32:0] mag34(input logic [33:0] v);
      logic [33:0] n;
      n = -v;
      return v[33] ? n[32:0] : v[32:0];
   endfunction

   always_comb begin
      ea = err_ff[31] ? 33'(-{err_ff[31], err_ff}) : {1'b0, err_ff};
      sa = sp_ff[31] ? 33'(-{sp_ff[31], sp_ff}) : {1'b0, sp_ff};
      dsp = {{2{sp_ff[31]}}, sp_ff} - {{2{tgt_ff[31]}}, tgt_ff};
      dsp_mag = mag34(dsp);
      dms = {{2{meas_ff[31]}}, meas_ff} - {{2{sp_ff[31]}}, sp_ff};
      dms_mag = mag34(dms);
      start_step = !trk_ff && (dsp_mag > {2'b00, threshold_ff});
      trk_now = trk_ff || start_step;
      peak_now = start_step ? meas_ff : ((meas_ff > peak_ff) ? meas_ff : peak_ff);
      tgt_now = start_step ? sp_ff : tgt_ff;
      init_now = start_step ? meas_ff : init_ff;
      dos_num = {{2{peak_now[31]}}, peak_now} - {{2{tgt_now[31]}}, tgt_now};
      dos_den = {{2{tgt_now[31]}}, tgt_now} - {{2{init_now[31]}}, init_now};
      num_mag = mag34(dos_num);
      den_mag = mag34(dos_den);
      band = mul_p[63:16];
      if (band < {17'd0, floor_ff}) band = {17'd0, floor_ff};
   end

   function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                                input logic [47:0] b);
      logic [48:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s > {2'b00, AccMax}) ? AccMax : s[AccW-1:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_metrics_valid = lv_ff;
   assign rsp_tracking = trk_ff;
   assign rsp_settling_time_us = lt_ff;
   assign rsp_overshoot_pct = los_ff;
   assign rsp_steady_error = lse_ff;
   assign rsp_iae_out = liae_ff;
   assign rsp_ise_out = lise_ff;

   always_comb begin
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      dreq.start = 1'b0;
      dreq.num = tmp_ff;
      dreq.den = den_ff;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_M_IAE;
         S_M_IAE: begin
            if (op_ff == OP_CLEAR || !enable_ff) begin
               state_in = S_RESP;
            end else begin
               mul_start = 1'b1;
               mul_a = ea[31:0];
               mul_b = {16'd0, weight_ff};
               state_in = S_M_SQ;
            end
         end
         S_M_SQ: if (mul_done) begin
            mul_start = 1'b1;
            mul_a = ea[31:0];
            mul_b = ea[31:0];
            state_in = S_M_ISE;
         end
         S_M_ISE: if (mul_done) begin
            mul_start = 1'b1;
            mul_a = mul_p[47:16];
            mul_b = {16'd0, weight_ff};
            state_in = S_M_ISH;
         end
         S_M_ISH: if (mul_done) begin
            mul_start = 1'b1;
            mul_a = {17'd0, sqhi_ff};
            mul_b = {16'd0, weight_ff};
            state_in = S_M_BND;
         end
         S_M_BND: if (mul_done) begin
            mul_start = 1'b1;
            mul_a = sa[31:0];
            mul_b = {16'd0, fraction_ff};
            state_in = S_DECIDE;
         end
         S_DECIDE: if (mul_done) begin
            if (trk_now && ({15'd0, dms_mag} < band)) begin
               mul_start = 1'b1;
               mul_a = num_mag[31:0];
               mul_b = 32'd100;
               state_in = S_M_OS1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_M_OS1: if (mul_done) state_in = S_M_OS2;
         S_M_OS2: begin
            state_in = (den_ff == 32'd0) ? S_FIN : S_DIV;
            dreq.start = (den_ff != 32'd0);
         end
         S_DIV: if (drsp.done) state_in = S_FIN;
         S_FIN: state_in = S_RESP;
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // The ISE square takes a 33-bit magnitude; its largest value, |e| = 2^31,
   // still fits the multiplier input ea[31:0] = 2^31, and its square 2^62 fits
   // the 64-bit product path.

   logic settle_ff;
   logic [47:0] iae_add_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         enable_ff <= 1'b1;
         threshold_ff <= 31'd32768;
         fraction_ff <= 16'd1311;
         floor_ff <= 31'd655;
         weight_ff <= 16'd6554;
         trk_ff <= 1'b0;
         init_ff <= '0;
         tgt_ff <= '0;
         start_ff <= '0;
         peak_ff <= '0;
         iae_ff <= '0;
         ise_ff <= '0;
         lv_ff <= 1'b0;
         lt_ff <= '0;
         los_ff <= '0;
         lse_ff <= '0;
         liae_ff <= '0;
         lise_ff <= '0;
         settle_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_ENABLE: enable_ff <= csr_data[0];
               CSR_STEP_THRESHOLD: threshold_ff <= csr_data[30:0];
               CSR_SETTLE_FRACTION: fraction_ff <= csr_data[15:0];
               CSR_SETTLE_FLOOR: floor_ff <= csr_data[30:0];
               CSR_SAMPLE_WEIGHT: weight_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: settle_ff <= 1'b0;
            S_M_IAE: if (op_ff == OP_CLEAR) begin
               iae_ff <= '0;
               ise_ff <= '0;
               trk_ff <= 1'b0;
               lv_ff <= 1'b0;
               lt_ff <= '0;
               los_ff <= '0;
               lse_ff <= '0;
               liae_ff <= '0;
               lise_ff <= '0;
            end
            S_M_SQ: if (mul_done) iae_add_ff <= mul_p[63:16];
            S_M_ISE: if (mul_done) sqhi_ff <= mul_p[62:48];
            S_M_ISH: if (mul_done) isel_ff <= mul_p[63:16];
            S_M_BND: if (mul_done) begin
               iae_ff <= sat_add(iae_ff, iae_add_ff);
               ise_ff <= sat_add(ise_ff, isel_ff + {mul_p[31:0], 16'd0});
            end
            S_DECIDE: if (mul_done) begin
               settle_ff <= trk_now && ({15'd0, dms_mag} < band);
               neg_ff <= dos_num[33] != dos_den[33];
               den_ff <= den_mag[31:0];
               if (start_step) begin
                  init_ff <= meas_ff;
                  tgt_ff <= sp_ff;
                  start_ff <= t_ff;
                  iae_ff <= '0;
                  ise_ff <= '0;
                  lv_ff <= 1'b0;
               end
               if (trk_now) peak_ff <= peak_now;
               trk_ff <= trk_now;
            end
            S_M_OS1: if (mul_done) tmp_ff <= {mul_p[47:0], 16'd0};
            S_M_OS2: if (den_ff == 32'd0) tmp_ff <= 64'd0;
            S_DIV: if (drsp.done) tmp_ff <= drsp.quo;
            S_FIN: if (settle_ff) begin
               lt_ff <= t_ff - start_ff;
               lse_ff <= err_ff;
               liae_ff <= iae_ff;
               lise_ff <= ise_ff;
               lv_ff <= 1'b1;
               trk_ff <= 1'b0;
               if (neg_ff) begin
                  los_ff <= (tmp_ff > 64'h80000000) ? 32'sh80000000
                                                    : 32'(-tmp_ff[31:0]);
               end else begin
                  los_ff <= (tmp_ff > 64'h7FFFFFFF) ? 32'sh7FFFFFFF
                                                    : tmp_ff[31:0];
               end
            end
            default: ;
         endcase
      end
      if (req_valid && req_ready) begin
         op_ff <= req_opcode;
         t_ff <= req_time_us;
         sp_ff <= req_setpoint;
         meas_ff <= req_measured;
         err_ff <= req_loop_error;
      end
   end

`ifndef SYNTH
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request and response overlap");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_iae_out))
      else $error("response dropped");
   a_settle_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_metrics_valid && $rose(rsp_metrics_valid) |-> !rsp_tracking)
      else $error("tracking left on at settle");
`endif
endmodule
`default_nettype wire
